@@ hdl/lrd_pkg.sv @@
// Shared types, codes and the CRC-32 byte update for the log record deframer.
`default_nettype none

package lrd_pkg;

    localparam int OUTER_HEADER = 8;
    localparam int BODY_HEADER  = 18;
    localparam int M_TDATA_W    = 128;

    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNCATED = 2'd1;
    localparam logic [1:0] ST_CRC_FAIL  = 2'd2;
    localparam logic [1:0] ST_LEN_ERROR = 2'd3;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    typedef struct packed {
        logic       valid;
        logic       eol;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload;
        logic [1:0]  status;
        logic [7:0]  rec_op;
        logic [63:0] seq;
        logic [7:0]  tomb;
        logic [15:0] key_len;
        logic [15:0] val_len;
        logic        done;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/lrd_in_reg.sv @@
// Input register that holds one stream item until the parser takes it.
`default_nettype none

module lrd_in_reg (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic             s_eol,
    input  wire logic [7:0]       s_byte,
    input  wire logic             take,
    output lrd_pkg::in_item_t     item
);

    logic       valid_reg, valid_next;
    logic       eol_reg;
    logic [7:0] data_reg;

    assign s_tready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            eol_reg  <= s_eol;
            data_reg <= s_byte;
        end
    end

    assign item.valid = valid_reg;
    assign item.eol   = eol_reg;
    assign item.data  = data_reg;

endmodule

`default_nettype wire

@@ hdl/lrd_parser.sv @@
// Record parser: header capture, CRC check, payload selection and status generation.
`default_nettype none

module lrd_parser #(
    parameter int MAX_RECORD_LEN = 65536
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              fire,
    input  wire lrd_pkg::in_item_t item,
    output logic                   res_valid,
    output lrd_pkg::result_t       res
);

    localparam int POS_W = $clog2(MAX_RECORD_LEN + lrd_pkg::OUTER_HEADER + 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      len_reg, len_next;
    logic [31:0]      exp_crc_reg, exp_crc_next;
    logic [31:0]      crc_reg, crc_next;
    logic [7:0]       op_reg, op_next;
    logic [63:0]      seq_reg, seq_next;
    logic [7:0]       tomb_reg, tomb_next;
    logic [31:0]      klen_reg, klen_next;
    logic [23:0]      vlen_reg, vlen_next;
    logic [32:0]      kv_end_reg, kv_end_next;
    logic             bad_sizes_reg, bad_sizes_next;
    logic             halted_reg, halted_next;

    logic [POS_W-1:0] body;
    logic [POS_W-1:0] j;
    logic [31:0]      full_len;
    logic [32:0]      need;
    logic [31:0]      limit;
    logic             complete;

    assign complete = (pos_reg >= POS_W'(4)) &&
                      (pos_reg == len_reg[POS_W-1:0] + POS_W'(lrd_pkg::OUTER_HEADER));

    always_comb begin
        pos_next       = pos_reg;
        len_next       = len_reg;
        exp_crc_next   = exp_crc_reg;
        crc_next       = crc_reg;
        op_next        = op_reg;
        seq_next       = seq_reg;
        tomb_next      = tomb_reg;
        klen_next      = klen_reg;
        vlen_next      = vlen_reg;
        kv_end_next    = kv_end_reg;
        bad_sizes_next = bad_sizes_reg;
        halted_next    = halted_reg;
        res_valid      = 1'b0;
        res            = '0;
        body           = '0;
        j              = '0;
        full_len       = '0;
        need           = '0;
        limit          = '0;

        if (fire && !halted_reg) begin
            // A finished record reports its status before the new item is looked at.
            if (complete) begin
                res_valid = 1'b1;
                res.kind  = lrd_pkg::KIND_STATUS;
                res.done  = 1'b1;
                if (~crc_reg != exp_crc_reg) begin
                    res.status  = lrd_pkg::ST_CRC_FAIL;
                    halted_next = 1'b1;
                end else if (bad_sizes_reg) begin
                    res.status  = lrd_pkg::ST_LEN_ERROR;
                    halted_next = 1'b1;
                end else begin
                    res.status  = lrd_pkg::ST_OK;
                    res.rec_op  = op_reg;
                    res.seq     = seq_reg;
                    res.tomb    = tomb_reg;
                    res.key_len = klen_reg[15:0];
                    res.val_len = vlen_reg[15:0];
                end
                pos_next       = '0;
                len_next       = '0;
                exp_crc_next   = '0;
                crc_next       = lrd_pkg::CRC_INIT;
                op_next        = '0;
                seq_next       = '0;
                tomb_next      = '0;
                klen_next      = '0;
                vlen_next      = '0;
                kv_end_next    = '0;
                bad_sizes_next = 1'b0;
            end

            if (!halted_next) begin
                if (item.eol) begin
                    if (pos_next != '0) begin
                        res_valid   = 1'b1;
                        res         = '0;
                        res.kind    = lrd_pkg::KIND_STATUS;
                        res.status  = lrd_pkg::ST_TRUNCATED;
                        halted_next = 1'b1;
                    end
                end else if (pos_next < POS_W'(4)) begin
                    len_next[8*pos_next[1:0] +: 8] = item.data;
                    pos_next = pos_next + POS_W'(1);
                    if (pos_next == POS_W'(4)) begin
                        full_len = {item.data, len_reg[23:0]};
                        if (full_len < 32'(lrd_pkg::BODY_HEADER) ||
                            full_len > 32'(MAX_RECORD_LEN)) begin
                            res_valid   = 1'b1;
                            res         = '0;
                            res.kind    = lrd_pkg::KIND_STATUS;
                            res.status  = lrd_pkg::ST_LEN_ERROR;
                            halted_next = 1'b1;
                        end
                    end
                end else if (pos_next < POS_W'(lrd_pkg::OUTER_HEADER)) begin
                    exp_crc_next[8*pos_next[1:0] +: 8] = item.data;
                    pos_next = pos_next + POS_W'(1);
                end else begin
                    crc_next = lrd_pkg::crc_byte(crc_next, item.data);
                    body     = pos_next - POS_W'(lrd_pkg::OUTER_HEADER);
                    pos_next = pos_next + POS_W'(1);
                    if (body == POS_W'(0)) begin
                        op_next = item.data;
                    end else if (body <= POS_W'(8)) begin
                        seq_next[8*(3'(body - POS_W'(1))) +: 8] = item.data;
                    end else if (body == POS_W'(9)) begin
                        tomb_next = item.data;
                    end else if (body <= POS_W'(13)) begin
                        klen_next[8*(2'(body - POS_W'(10))) +: 8] = item.data;
                    end else if (body <= POS_W'(16)) begin
                        vlen_next[8*(2'(body - POS_W'(14))) +: 8] = item.data;
                    end else if (body == POS_W'(17)) begin
                        need  = {1'b0, klen_next} + {1'b0, item.data, vlen_next};
                        limit = len_next - 32'(lrd_pkg::BODY_HEADER);
                        kv_end_next    = need;
                        bad_sizes_next = need > {1'b0, limit};
                    end else if (!bad_sizes_next) begin
                        j = body - POS_W'(lrd_pkg::BODY_HEADER);
                        if (33'(j) < {1'b0, klen_next}) begin
                            res_valid   = 1'b1;
                            res         = '0;
                            res.kind    = lrd_pkg::KIND_KEY;
                            res.payload = item.data;
                        end else if (33'(j) < kv_end_next) begin
                            res_valid   = 1'b1;
                            res         = '0;
                            res.kind    = lrd_pkg::KIND_VALUE;
                            res.payload = item.data;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            len_reg       <= '0;
            exp_crc_reg   <= '0;
            crc_reg       <= lrd_pkg::CRC_INIT;
            op_reg        <= '0;
            seq_reg       <= '0;
            tomb_reg      <= '0;
            klen_reg      <= '0;
            vlen_reg      <= '0;
            kv_end_reg    <= '0;
            bad_sizes_reg <= 1'b0;
            halted_reg    <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            exp_crc_reg   <= exp_crc_next;
            crc_reg       <= crc_next;
            op_reg        <= op_next;
            seq_reg       <= seq_next;
            tomb_reg      <= tomb_next;
            klen_reg      <= klen_next;
            vlen_reg      <= vlen_next;
            kv_end_reg    <= kv_end_next;
            bad_sizes_reg <= bad_sizes_next;
            halted_reg    <= halted_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lrd_out_reg.sv @@
// Result register that packs one result item onto the master stream.
`default_nettype none

module lrd_out_reg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           load,
    input  wire logic                           res_valid,
    input  wire lrd_pkg::result_t               res,
    output logic                                free,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [lrd_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [1:0]                          m_tuser,
    output logic                                m_tlast
);

    logic             valid_reg, valid_next;
    lrd_pkg::result_t data_reg;

    assign free = !valid_reg || m_tready;

    always_comb begin
        if (load) begin
            valid_next = res_valid;
        end else begin
            valid_next = valid_reg && !m_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && res_valid) begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = data_reg.kind;
    assign m_tlast  = data_reg.done;
    assign m_tdata  = {6'd0, data_reg.val_len, data_reg.key_len, data_reg.tomb,
                       data_reg.seq, data_reg.rec_op, data_reg.status, data_reg.payload};

endmodule

`default_nettype wire

@@ hdl/log_record_deframer_core.sv @@
// Top level of the log record deframer: input register, parser and result register.
// Items pass the input register, the combinational parser and the result register.
// A record's status is caused by the item that follows the record's last byte.
// Throughput: one item per cycle while the result register is free.
// Reset (aresetn low, synchronous) clears both registers, the record state and the halt.
// After an error status the block keeps accepting items and drops them until reset.
`default_nettype none

module log_record_deframer_core #(
    parameter int MAX_RECORD_LEN = 65536
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,  // [7:0] data_byte
    input  wire logic                           s_tuser,  // [0] operation (end of log)
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [7:0] payload_byte, [9:8] status, [17:10] record_operation,
    // [81:18] sequence_number, [89:82] tombstone_flag, [105:90] key_length,
    // [121:106] value_length, [127:122] zero
    output logic [lrd_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [1:0]                          m_tuser,  // [1:0] item_kind
    output logic                                m_tlast   // record_done
);

    lrd_pkg::in_item_t item;
    lrd_pkg::result_t  res;
    logic              res_valid;
    logic              out_free;
    logic              advance;

    assign advance = item.valid && out_free;

    lrd_in_reg u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_eol    (s_tuser),
        .s_byte   (s_tdata),
        .take     (advance),
        .item     (item)
    );

    lrd_parser #(
        .MAX_RECORD_LEN (MAX_RECORD_LEN)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    lrd_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .res_valid (res_valid),
        .res       (res),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

@@ hdl/lrd_checker.sv @@
// Port-level checks for the log record deframer and their binding to the top level.
`default_nettype none

module lrd_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [7:0]                     s_tdata,
    input wire logic                           s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [lrd_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic [1:0]                     m_tuser,
    input wire logic                           m_tlast
);

    logic in_fire;
    assign in_fire = s_tvalid && s_tready && (s_tdata != 8'd0 || s_tuser != 1'b0 || 1'b1);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled result item changed.");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3 && m_tdata[127:122] == 6'd0)
        else $error("Result item has an unknown kind or nonzero fill.");

    a_data_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != lrd_pkg::KIND_STATUS |-> m_tdata[121:8] == '0 && !m_tlast)
        else $error("Key or value item carries status fields.");

    a_err_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == lrd_pkg::KIND_STATUS && m_tdata[9:8] != lrd_pkg::ST_OK
        |-> m_tdata[121:10] == '0 && m_tdata[7:0] == 8'd0 &&
            (m_tdata[9:8] != lrd_pkg::ST_TRUNCATED || !m_tlast))
        else $error("Error status carries header fields or a wrong done flag.");

    a_halt: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && m_tvalid && m_tready && m_tuser == lrd_pkg::KIND_STATUS &&
        m_tdata[9:8] != lrd_pkg::ST_OK |=> !m_tvalid)
        else $error("Result item after an error status.");

endmodule

bind log_record_deframer_core lrd_checker u_lrd_checker (.*);

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the log record deframer, with a cycle-free record predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lrd_pkg::*;

    localparam int MAX_RECORD_LEN = 65536;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int DRAIN_LIMIT    = 100000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    log_record_deframer_core #(
        .MAX_RECORD_LEN(MAX_RECORD_LEN)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Predicted deframer state.
    logic [16:0] pos_r;
    logic [31:0] len_r;
    logic [31:0] crc_exp_r;
    logic [31:0] crc_run_r;
    logic [7:0]  op_r;
    logic [63:0] seq_r;
    logic [7:0]  tomb_r;
    logic [31:0] klen_r;
    logic [31:0] vlen_r;
    logic        bad_sizes_r;
    logic        halted_r;

    result_t deframed_q[$];
    int      mismatch_count;
    int      sent_items;
    int      burst_left;
    int      hold_off_request;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #8000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            if (c[0] ^ b[i]) begin
                c = {1'b0, c[31:1]} ^ CRC_POLY;
            end else begin
                c = {1'b0, c[31:1]};
            end
        end
        return c;
    endfunction

    function automatic result_t status_item(input logic [1:0] code, input logic done);
        result_t r;
        r = '0;
        r.kind = KIND_STATUS;
        r.status = code;
        r.done = done;
        if (code == ST_OK) begin
            r.rec_op = op_r;
            r.seq = seq_r;
            r.tomb = tomb_r;
            r.key_len = klen_r[15:0];
            r.val_len = vlen_r[15:0];
        end
        return r;
    endfunction

    function automatic result_t payload_item(input logic [1:0] kind, input logic [7:0] b);
        result_t r;
        r = '0;
        r.kind = kind;
        r.payload = b;
        return r;
    endfunction

    task automatic clear_record();
        pos_r = '0;
        len_r = '0;
        crc_exp_r = '0;
        crc_run_r = CRC_INIT;
        op_r = '0;
        seq_r = '0;
        tomb_r = '0;
        klen_r = '0;
        vlen_r = '0;
        bad_sizes_r = 1'b0;
    endtask

    task automatic deframe_byte(input logic eol, input logic [7:0] b);
        int p;
        int k;
        longint unsigned j;
        if (halted_r) begin
            return;
        end
        // The record that ended on the previous item reports its status now.
        if (pos_r >= 4 && {47'd0, pos_r} == 64'd8 + {32'd0, len_r}) begin
            if (~crc_run_r != crc_exp_r) begin
                deframed_q.push_back(status_item(ST_CRC_FAIL, 1'b1));
                halted_r = 1'b1;
            end else if (bad_sizes_r) begin
                deframed_q.push_back(status_item(ST_LEN_ERROR, 1'b1));
                halted_r = 1'b1;
            end else begin
                deframed_q.push_back(status_item(ST_OK, 1'b1));
            end
            clear_record();
            if (halted_r) begin
                return;
            end
        end
        if (eol) begin
            if (pos_r != 0) begin
                deframed_q.push_back(status_item(ST_TRUNCATED, 1'b0));
                halted_r = 1'b1;
            end
            return;
        end
        p = pos_r;
        pos_r = pos_r + 1'b1;
        if (p < 4) begin
            len_r = len_r | (32'(b) << (8 * p));
            if (p == 3 && (len_r < BODY_HEADER || len_r > MAX_RECORD_LEN)) begin
                deframed_q.push_back(status_item(ST_LEN_ERROR, 1'b0));
                halted_r = 1'b1;
            end
            return;
        end
        if (p < OUTER_HEADER) begin
            crc_exp_r = crc_exp_r | (32'(b) << (8 * (p - 4)));
            return;
        end
        crc_run_r = crc32_update(crc_run_r, b);
        k = p - OUTER_HEADER;
        if (k == 0) begin
            op_r = b;
        end else if (k <= 8) begin
            seq_r = seq_r | (64'(b) << (8 * (k - 1)));
        end else if (k == 9) begin
            tomb_r = b;
        end else if (k <= 13) begin
            klen_r = klen_r | (32'(b) << (8 * (k - 10)));
        end else if (k <= 17) begin
            vlen_r = vlen_r | (32'(b) << (8 * (k - 14)));
            if (k == 17) begin
                bad_sizes_r = ({32'd0, klen_r} + {32'd0, vlen_r}) > {32'd0, len_r - 32'd18};
            end
        end else if (!bad_sizes_r) begin
            j = k - BODY_HEADER;
            if (j < klen_r) begin
                deframed_q.push_back(payload_item(KIND_KEY, b));
            end else if (j - klen_r < vlen_r) begin
                deframed_q.push_back(payload_item(KIND_VALUE, b));
            end
        end
    endtask

    // Starts and ends at a falling edge; valid is only lowered when a gap begins.
    task automatic send_item(input logic eol, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= eol;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        deframe_byte(eol, b);
        sent_items++;
        @(negedge aclk);
    endtask

    task automatic send_eol();
        send_item(1'b1, 8'($urandom));
    endtask

    // Sends the first cut bytes of a framed record, or all of it when cut is zero.
    task automatic send_record(input logic [7:0] op, input logic [63:0] seq,
                               input logic [7:0] tomb, input logic [31:0] klen,
                               input logic [31:0] vlen, input int n_payload,
                               input int n_trail, input logic corrupt_crc, input int cut);
        logic [7:0]  body[$];
        logic [7:0]  frame[$];
        logic [31:0] crc;
        logic [31:0] rec_len;
        int          n;
        body.push_back(op);
        for (int i = 0; i < 8; i++) body.push_back(seq[8*i +: 8]);
        body.push_back(tomb);
        for (int i = 0; i < 4; i++) body.push_back(klen[8*i +: 8]);
        for (int i = 0; i < 4; i++) body.push_back(vlen[8*i +: 8]);
        repeat (n_payload + n_trail) body.push_back(8'($urandom));
        crc = CRC_INIT;
        foreach (body[i]) crc = crc32_update(crc, body[i]);
        crc = ~crc;
        if (corrupt_crc) begin
            crc = crc ^ (32'd1 << $urandom_range(0, 31));
        end
        rec_len = body.size();
        for (int i = 0; i < 4; i++) frame.push_back(rec_len[8*i +: 8]);
        for (int i = 0; i < 4; i++) frame.push_back(crc[8*i +: 8]);
        frame = {frame, body};
        n = (cut == 0) ? frame.size() : cut;
        for (int i = 0; i < n; i++) send_item(1'b0, frame[i]);
    endtask

    task automatic send_random_record();
        int klen;
        int vlen;
        int trail;
        klen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 100) : $urandom_range(0, 12);
        vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 100) : $urandom_range(0, 12);
        trail = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
        send_record(8'($urandom), {$urandom, $urandom}, 8'($urandom), klen, vlen,
                    klen + vlen, trail, 1'b0, 0);
    endtask

    task automatic test_directed_records();
        send_eol();
        send_eol();
        send_record(8'h00, 64'd0, 8'h00, 0, 0, 0, 0, 1'b0, 0);
        send_record(8'hFF, '1, 8'hFF, 1, 0, 1, 0, 1'b0, 0);
        send_record(8'h5A, 64'h0123_4567_89AB_CDEF, 8'h01, 0, 3, 3, 2, 1'b0, 0);
        send_eol();
        send_eol();
        send_record(8'h02, 64'h8000_0000_0000_0001, 8'h00, 4, 4, 8, 5, 1'b0, 0);
        // A longer record whose key and value each span several bursts.
        send_record(8'h01, {$urandom, $urandom}, 8'h00, 70, 90, 160, 0, 1'b0, 0);
        send_record(8'h03, {$urandom, $urandom}, 8'h80, 2, 2, 4, 0, 1'b0, 0);
        send_eol();
    endtask

    task automatic test_random_records();
        int start;
        start = sent_items;
        while (sent_items - start < RANDOM_ITEMS) begin
            send_random_record();
            if ($urandom_range(0, 7) == 0) begin
                send_eol();
                if ($urandom_range(0, 1) == 0) send_eol();
            end
        end
    endtask

    task automatic test_receiver_hold_off();
        hold_off_request = 400;
        send_record(8'($urandom), {$urandom, $urandom}, 8'($urandom), 60, 60, 120, 0, 1'b0, 0);
        send_random_record();
    endtask

    // Only one error can be seen per run, since the block halts until reset.
    task automatic test_error_halts();
        int          choice;
        int          klen;
        int          vlen;
        logic [31:0] bad_len;
        choice = $urandom_range(0, 6);
        klen = $urandom_range(1, 20);
        vlen = $urandom_range(0, 20);
        case (choice)
            0: begin
                send_record(8'($urandom), {$urandom, $urandom}, 8'($urandom), klen, vlen,
                            klen + vlen, 0, 1'b0, $urandom_range(1, 25 + klen + vlen));
                send_eol();
            end
            1: begin
                send_record(8'($urandom), {$urandom, $urandom}, 8'($urandom), klen, vlen,
                            klen + vlen, $urandom_range(0, 3), 1'b1, 0);
            end
            2: begin
                bad_len = ($urandom_range(0, 1) == 0) ? 32'd17 : $urandom_range(0, 17);
                for (int i = 0; i < 4; i++) send_item(1'b0, bad_len[8*i +: 8]);
            end
            3: begin
                case ($urandom_range(0, 2))
                    0: bad_len = MAX_RECORD_LEN + 1;
                    1: bad_len = '1;
                    default: bad_len = $urandom_range(MAX_RECORD_LEN + 1, 32'hFFFF_FFFE);
                endcase
                for (int i = 0; i < 4; i++) send_item(1'b0, bad_len[8*i +: 8]);
            end
            4, 5: begin
                send_record(8'($urandom), {$urandom, $urandom}, 8'($urandom), klen, vlen,
                            $urandom_range(0, klen + vlen - 1), 0, choice == 5, 0);
            end
            default: begin
                send_record(8'($urandom), {$urandom, $urandom}, 8'($urandom),
                            32'h0001_0000 | klen, vlen, vlen + 2, 0, 1'b0, 0);
            end
        endcase
        // Everything after the error must be dropped.
        send_random_record();
        send_eol();
        repeat (10) send_item(1'($urandom_range(0, 1)), 8'($urandom));
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (deframed_q.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual kind %0d tdata %h",
                         $time, m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                want = deframed_q.pop_front();
                compare_field("item_kind", want.kind, m_tuser);
                compare_field("payload_byte", want.payload, m_tdata[7:0]);
                compare_field("status", want.status, m_tdata[9:8]);
                compare_field("record_operation", want.rec_op, m_tdata[17:10]);
                compare_field("sequence_number", want.seq, m_tdata[81:18]);
                compare_field("tombstone_flag", want.tomb, m_tdata[89:82]);
                compare_field("key_length", want.key_len, m_tdata[105:90]);
                compare_field("value_length", want.val_len, m_tdata[121:106]);
                compare_field("record_done", want.done, m_tlast);
            end
        end
    end

    initial begin : receiver
        int mode;
        int mode_left;
        int held;
        int tick;
        mode = 0;
        mode_left = 0;
        held = 0;
        tick = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            tick++;
            if (hold_off_request != 0) begin
                held = hold_off_request;
                hold_off_request = 0;
            end
            if (held > 0) begin
                held--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= (tick % 4) != 3;
                endcase
            end
        end
    end

    initial begin : main
        int waited;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        mismatch_count = 0;
        sent_items = 0;
        burst_left = 0;
        hold_off_request = 0;
        halted_r = 1'b0;
        clear_record();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_records();
        test_random_records();
        test_receiver_hold_off();
        test_error_halts();
        s_tvalid <= 1'b0;

        waited = 0;
        while (deframed_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (20) @(posedge aclk);
        if (deframed_q.size() != 0) begin
            $display("%0t: %0d items never arrived, expected kind %0d, actual none",
                     $time, deframed_q.size(), deframed_q[0].kind);
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ log_record_deframer_core.f @@
hdl/lrd_pkg.sv
hdl/lrd_in_reg.sv
hdl/lrd_parser.sv
hdl/lrd_out_reg.sv
hdl/log_record_deframer_core.sv
hdl/lrd_checker.sv
tb/sv/testbench.sv
